// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion macros; they expect clk and arst_n in the scope that uses them.

// The expression holds at every clock edge outside reset.
`define SCP_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("scp assertion failed");

// Whenever the antecedent holds, the consequent follows.
`define SCP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scp assertion failed");

`endif

// ----- design/scp_pkg.sv -----
// Types, widths and constants shared by the swept sphere pair collision pipeline.
`default_nettype none

package scp_pkg;

	function automatic int wmax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	localparam int COORD_W = 24;
	localparam int VEL_W   = 20;
	localparam int RAD_W   = 20;

	// Derived widths. All of them are exact, so no stage ever wraps.
	localparam int DP_W      = COORD_W + 1;
	localparam int RSUM_W    = RAD_W + 1;
	localparam int SQ_TERM_W = 2 * COORD_W;
	localparam int SQ_W      = 2 * COORD_W + 2;
	localparam int RR_W      = 2 * RSUM_W;
	localparam int CMP_W     = wmax(SQ_W, RR_W);
	localparam int PP_W      = SQ_W;
	localparam int DPDV_W    = DP_W + VEL_W;
	localparam int PV_W      = COORD_W + VEL_W + 2;
	localparam int PVM_W     = COORD_W + VEL_W + 1;
	localparam int DVSQ_W    = 2 * VEL_W - 1;
	localparam int VV_W      = 2 * VEL_W;
	localparam int SUM_W     = wmax(PV_W, VV_W + 1) + 1;
	localparam int APT_W     = wmax(wmax(PP_W, VV_W), PVM_W + 1) + 1;

	// Operand splits for the wide closest-approach products.
	localparam int PP_LO_W  = PP_W / 2;
	localparam int PP_HI_W  = PP_W - PP_LO_W;
	localparam int VV_LO_W  = VV_W / 2;
	localparam int VV_HI_W  = VV_W - VV_LO_W;
	localparam int PVM_LO_W = PVM_W / 2;
	localparam int PVM_HI_W = PVM_W - PVM_LO_W;
	localparam int WIDE_W   = PP_W + VV_W;

	// Clock edges from an accepted item to the edge that takes its result.
	localparam int RESULT_LAT = 8;

	typedef enum logic [1:0] {
		DEC_OVERLAP    = 2'd0,
		DEC_SEPARATING = 2'd1,
		DEC_APART      = 2'd2,
		DEC_CLOSEST    = 2'd3
	} scp_decision_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] second_z;
		logic signed [VEL_W-1:0]   rel_vel_x;
		logic signed [VEL_W-1:0]   rel_vel_y;
		logic signed [VEL_W-1:0]   rel_vel_z;
		logic [RAD_W-1:0]          first_radius;
		logic [RAD_W-1:0]          second_radius;
	} scp_query_t;

	typedef struct packed {
		logic          collides;
		scp_decision_t decided_by;
	} scp_result_t;

	// Front half to back half: early decisions and the reduced terms.
	typedef struct packed {
		logic             overlap;
		logic             sep;
		logic             near;
		logic [PP_W-1:0]  pp;
		logic [VV_W-1:0]  vv;
		logic [PVM_W-1:0] pvmag;
	} scp_mid_t;

	// Back half to the decision stage.
	typedef struct packed {
		logic              overlap;
		logic              sep;
		logic              apart;
		logic [WIDE_W-1:0] lhs;
		logic [WIDE_W-1:0] rhs;
	} scp_tail_t;

endpackage

`default_nettype wire

// ----- design/scp_front.sv -----
// Stages one to four: offsets, products, dot-product sums and early tests.
`default_nettype none

module scp_front import scp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  scp_query_t query,
	output logic       mid_valid,
	output scp_mid_t   mid
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [DP_W-1:0]   dp_s1 [3];
	logic signed [VEL_W-1:0]  dv_s1 [3];
	logic [RSUM_W-1:0]        r_s1;

	logic [SQ_TERM_W-1:0]     dpsq_s2 [3];
	logic signed [DPDV_W-1:0] dpdv_s2 [3];
	logic [DVSQ_W-1:0]        dvsq_s2 [3];
	logic [RR_W-1:0]          rr_s2;

	logic [SQ_W-1:0]          sq_s3;
	logic signed [PV_W-1:0]   pv_s3;
	logic [VV_W-1:0]          vv_s3;
	logic [RR_W-1:0]          rr_s3;

	scp_mid_t                 mid_s4;

	logic signed [2*DP_W-1:0]  dpsq_c [3];
	logic signed [DPDV_W-1:0]  dpdv_c [3];
	logic signed [2*VEL_W-1:0] dvsq_c [3];

	logic [CMP_W-1:0]         sq_ext_c, rr_ext_c, diff_c;
	logic signed [PV_W-1:0]   pvneg_c;
	logic signed [SUM_W-1:0]  pvvv_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: center offset with one guard bit, radius sum.
	always_ff @(posedge clk) begin
		dp_s1[0] <= {query.second_x[COORD_W-1], query.second_x}
			- {query.first_x[COORD_W-1], query.first_x};
		dp_s1[1] <= {query.second_y[COORD_W-1], query.second_y}
			- {query.first_y[COORD_W-1], query.first_y};
		dp_s1[2] <= {query.second_z[COORD_W-1], query.second_z}
			- {query.first_z[COORD_W-1], query.first_z};
		dv_s1[0] <= query.rel_vel_x;
		dv_s1[1] <= query.rel_vel_y;
		dv_s1[2] <= query.rel_vel_z;
		r_s1     <= {1'b0, query.first_radius} + {1'b0, query.second_radius};
	end

	// Stage 2: one multiplier per term.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dpsq_c[i] = dp_s1[i] * dp_s1[i];
			dpdv_c[i] = dp_s1[i] * dv_s1[i];
			dvsq_c[i] = dv_s1[i] * dv_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dpsq_s2[i] <= dpsq_c[i][SQ_TERM_W-1:0];
			dpdv_s2[i] <= dpdv_c[i];
			dvsq_s2[i] <= dvsq_c[i][DVSQ_W-1:0];
		end
		rr_s2 <= r_s1 * r_s1;
	end

	// Stage 3: three-term sums.
	always_ff @(posedge clk) begin
		sq_s3 <= SQ_W'(dpsq_s2[0]) + SQ_W'(dpsq_s2[1]) + SQ_W'(dpsq_s2[2]);
		pv_s3 <= PV_W'(dpdv_s2[0]) + PV_W'(dpdv_s2[1]) + PV_W'(dpdv_s2[2]);
		vv_s3 <= VV_W'(dvsq_s2[0]) + VV_W'(dvsq_s2[1]) + VV_W'(dvsq_s2[2]);
		rr_s3 <= rr_s2;
	end

	// Stage 4: overlap, separation and the sign of pv + vv.
	always_comb begin
		sq_ext_c = CMP_W'(sq_s3);
		rr_ext_c = CMP_W'(rr_s3);
		diff_c   = sq_ext_c - rr_ext_c;
		pvneg_c  = -pv_s3;
		pvvv_c   = SUM_W'(pv_s3) + $signed(SUM_W'(vv_s3));
	end

	always_ff @(posedge clk) begin
		mid_s4.overlap <= sq_ext_c < rr_ext_c;
		mid_s4.sep     <= !pv_s3[PV_W-1];
		mid_s4.near    <= pvvv_c[SUM_W-1] || (pvvv_c == '0);
		mid_s4.pp      <= PP_W'(diff_c);
		mid_s4.vv      <= vv_s3;
		mid_s4.pvmag   <= pv_s3[PV_W-1] ? pvneg_c[PVM_W-1:0] : pv_s3[PVM_W-1:0];
	end

	assign mid_valid = valid_s4;
	assign mid       = mid_s4;

endmodule

`default_nettype wire

// ----- design/scp_back.sv -----
// Stages five to seven: frame-end test and the split wide products.
`default_nettype none

module scp_back import scp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_valid,
	input  scp_mid_t  mid,
	output logic      tail_valid,
	output scp_tail_t tail
);

	logic valid_s5, valid_s6, valid_s7;

	logic overlap_s5, sep_s5, apart_s5;
	logic overlap_s6, sep_s6, apart_s6;

	logic [PP_HI_W+VV_HI_W-1:0]   phh_s5;
	logic [PP_HI_W+VV_LO_W-1:0]   phl_s5;
	logic [PP_LO_W+VV_HI_W-1:0]   plh_s5;
	logic [PP_LO_W+VV_LO_W-1:0]   pll_s5;
	logic [2*PVM_HI_W-1:0]        qhh_s5;
	logic [PVM_HI_W+PVM_LO_W-1:0] qhl_s5;
	logic [2*PVM_LO_W-1:0]        qll_s5;

	logic [WIDE_W-1:0] lhs_a_s6, lhs_b_s6, rhs_a_s6, rhs_b_s6;

	scp_tail_t tail_s7;

	logic [PP_HI_W-1:0]  pph_c;
	logic [PP_LO_W-1:0]  ppl_c;
	logic [VV_HI_W-1:0]  vvh_c;
	logic [VV_LO_W-1:0]  vvl_c;
	logic [PVM_HI_W-1:0] pvh_c;
	logic [PVM_LO_W-1:0] pvl_c;
	logic [APT_W-1:0]    end_lhs_c, end_rhs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s5 <= mid_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		pph_c     = mid.pp[PP_W-1:PP_LO_W];
		ppl_c     = mid.pp[PP_LO_W-1:0];
		vvh_c     = mid.vv[VV_W-1:VV_LO_W];
		vvl_c     = mid.vv[VV_LO_W-1:0];
		pvh_c     = mid.pvmag[PVM_W-1:PVM_LO_W];
		pvl_c     = mid.pvmag[PVM_LO_W-1:0];
		end_lhs_c = APT_W'(mid.pp) + APT_W'(mid.vv);
		end_rhs_c = APT_W'({mid.pvmag, 1'b0});
	end

	// Stage 5: the spheres stay apart through the frame end when pv + vv is not
	// positive and the distance there, pp + 2*pv + vv, is not negative.
	always_ff @(posedge clk) begin
		overlap_s5 <= mid.overlap;
		sep_s5     <= mid.sep;
		apart_s5   <= mid.near && !(end_lhs_c < end_rhs_c);
		phh_s5     <= pph_c * vvh_c;
		phl_s5     <= pph_c * vvl_c;
		plh_s5     <= ppl_c * vvh_c;
		pll_s5     <= ppl_c * vvl_c;
		qhh_s5     <= pvh_c * pvh_c;
		qhl_s5     <= pvh_c * pvl_c;
		qll_s5     <= pvl_c * pvl_c;
	end

	// Stage 6: align partial products.
	always_ff @(posedge clk) begin
		overlap_s6 <= overlap_s5;
		sep_s6     <= sep_s5;
		apart_s6   <= apart_s5;
		lhs_a_s6   <= (WIDE_W'(phh_s5) << (PP_LO_W + VV_LO_W)) + WIDE_W'(pll_s5);
		lhs_b_s6   <= (WIDE_W'(phl_s5) << PP_LO_W) + (WIDE_W'(plh_s5) << VV_LO_W);
		rhs_a_s6   <= (WIDE_W'(qhh_s5) << (2 * PVM_LO_W)) + WIDE_W'(qll_s5);
		rhs_b_s6   <= WIDE_W'(qhl_s5) << (PVM_LO_W + 1);
	end

	// Stage 7: pp*vv and pv*pv in full.
	always_ff @(posedge clk) begin
		tail_s7.overlap <= overlap_s6;
		tail_s7.sep     <= sep_s6;
		tail_s7.apart   <= apart_s6;
		tail_s7.lhs     <= lhs_a_s6 + lhs_b_s6;
		tail_s7.rhs     <= rhs_a_s6 + rhs_b_s6;
	end

	assign tail_valid = valid_s7;
	assign tail       = tail_s7;

endmodule

`default_nettype wire

// ----- design/swept_sphere_pair_collision.sv -----
// Swept sphere pair collision test: top level with the final decision stage.
// done is high in the cycle in which result carries the outcome for a taken item.
// Throughput: one item per cycle; busy is always low since the receiver never stalls.
// Eight register stages set the latency, each stage one multiplier or one wide add.
// Reset clears only the stage valid bits; arithmetic registers are not reset.
`default_nettype none

module swept_sphere_pair_collision import scp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  scp_query_t  query,
	output logic        done,
	output scp_result_t result
);

	logic      in_valid;
	logic      mid_valid;
	scp_mid_t  mid;
	logic      tail_valid;
	scp_tail_t tail;

	logic        valid_s8;
	scp_result_t result_s8;

	// Every stage advances each cycle, so an item is taken whenever start is high.
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	// Stages one to four form the offsets, the three dot products and the
	// tests that need only signs: overlap now, moving apart and the sign of pv + vv.
	scp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.query     (query),
		.mid_valid (mid_valid),
		.mid       (mid)
	);

	// Stages five to seven check the end-of-frame distance and build the
	// exact products pp*vv and pv*pv from narrow partial products.
	scp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_valid  (mid_valid),
		.mid        (mid),
		.tail_valid (tail_valid),
		.tail       (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= tail_valid;
		end
	end

	// Stage 8: the tests are taken in priority order. Exact touching is not
	// an overlap, and when the spheres approach but stay apart through the
	// frame end, the closest-approach compare is skipped. Otherwise contact
	// within the frame is given by pp*vv < pv^2.
	always_ff @(posedge clk) begin
		if (tail.overlap) begin
			result_s8.collides   <= 1'b1;
			result_s8.decided_by <= DEC_OVERLAP;
		end else if (tail.sep) begin
			result_s8.collides   <= 1'b0;
			result_s8.decided_by <= DEC_SEPARATING;
		end else if (tail.apart) begin
			result_s8.collides   <= 1'b0;
			result_s8.decided_by <= DEC_APART;
		end else begin
			result_s8.collides   <= tail.lhs < tail.rhs;
			result_s8.decided_by <= DEC_CLOSEST;
		end
	end

	assign done   = valid_s8;
	assign result = result_s8;

endmodule

`default_nettype wire

// ----- design/scp_checker.sv -----
// Port-level checker for the swept sphere pair collision block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module scp_checker import scp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input scp_result_t result
);

	`SCP_ASSERT_ALWAYS(a_never_busy, !busy)
	`SCP_ASSERT_IMPLY(a_item_gets_result, start && !busy, ##RESULT_LAT done)
	`SCP_ASSERT_IMPLY(a_no_stray_result, done, $past(start && !busy, RESULT_LAT))
	`SCP_ASSERT_IMPLY(a_early_decision, done && result.decided_by != DEC_CLOSEST, result.collides == (result.decided_by == DEC_OVERLAP))

endmodule

bind swept_sphere_pair_collision scp_checker u_scp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
